// File: hdl/ita_pkg.sv
`default_nettype none

package ita_pkg;

    // Format commands carried with each number.
    localparam logic [1:0] CMD_UNSIGNED = 2'd0;
    localparam logic [1:0] CMD_SIGNED   = 2'd1;
    localparam logic [1:0] CMD_HEX      = 2'd2;

    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_LOWER_A = 7'h61;

    // Classification of one request, travels with the magnitude.
    typedef struct packed {
        logic negative;
        logic hex;
    } ita_kind_t;

    localparam int KIND_BITS = 2;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_CONVERT,
        BACK_TRIM,
        BACK_EMIT
    } ita_back_state_t;

    function automatic logic [6:0] digit_char(input logic [3:0] digit);
        logic [6:0] ch;
        if (digit < 4'd10)
        begin
            ch = CHAR_ZERO + {3'b000, digit};
        end
        else
        begin
            ch = CHAR_LOWER_A + {3'b000, digit - 4'd10};
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ita_front.sv
`default_nettype none

module ita_front #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic [31:0]           value,
    input  wire logic [1:0]            command,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  queue_full,
    output logic                       queue_write,
    output logic [VALUE_BITS-1:0]      queue_magnitude,
    output ita_pkg::ita_kind_t         queue_kind
);

    logic [VALUE_BITS+31:0] value_ext;
    logic [VALUE_BITS-1:0]  masked;
    logic                   is_negative;

    assign value_ext = {{VALUE_BITS{1'b0}}, value};
    assign masked    = value_ext[VALUE_BITS-1:0];

    // Only the signed decimal command looks at the sign bit; command 3 acts as hex.
    assign is_negative = (command == ita_pkg::CMD_SIGNED) && masked[VALUE_BITS-1];

    always_comb
    begin
        queue_kind.negative = is_negative;
        queue_kind.hex      = command[1];
        if (is_negative)
        begin
            queue_magnitude = -masked;
        end
        else
        begin
            queue_magnitude = masked;
        end
    end

    assign full        = queue_full;
    assign queue_write = push && !queue_full;

endmodule

`default_nettype wire

// File: hdl/ita_queue.sv
`default_nettype none

module ita_queue #(
    parameter int WIDTH = 34
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             write,
    input  wire logic [WIDTH-1:0] write_data,
    output logic                  queue_full,
    input  wire logic             read,
    output logic [WIDTH-1:0]      read_data,
    output logic                  queue_empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_write;
    logic             do_read;

    assign queue_full  = (count_reg == 2'd2);
    assign queue_empty = (count_reg == 2'd0);
    assign do_write    = write && !queue_full;
    assign do_read     = read && !queue_empty;
    assign read_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_write ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_read ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_write && !do_read)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_read && !do_write)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            entry_reg[wr_ptr_reg] <= write_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ita_back.sv
`default_nettype none

module ita_back #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  queue_empty,
    input  wire logic [VALUE_BITS-1:0] queue_magnitude,
    input  wire ita_pkg::ita_kind_t    queue_kind,
    output logic                       queue_read,
    output logic [6:0]                 character,
    output logic                       last,
    output logic                       empty,
    input  wire logic                  pop
);

    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int DIG_W      = DEC_DIGITS * 4;
    localparam int CNT_W      = $clog2(DEC_DIGITS + 1);
    localparam int BIT_W      = $clog2(VALUE_BITS + 1);
    localparam int HEX_SHIFT  = 4 * (DEC_DIGITS - HEX_DIGITS);

    ita_pkg::ita_back_state_t state_reg;
    ita_pkg::ita_back_state_t state_next;

    logic [DIG_W-1:0]      digits_reg;
    logic [DIG_W-1:0]      digits_next;
    logic [VALUE_BITS-1:0] bin_reg;
    logic [VALUE_BITS-1:0] bin_next;
    logic [BIT_W-1:0]      bit_cnt_reg;
    logic [BIT_W-1:0]      bit_cnt_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  sign_reg;
    logic                  sign_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [6:0]            char_reg;
    logic [6:0]            char_next;
    logic                  last_reg;
    logic                  last_next;

    logic [DIG_W-1:0]      adjusted;
    logic [DIG_W-1:0]      hex_aligned;
    logic [3:0]            top_digit;
    logic                  slot_free;

    assign hex_aligned = DIG_W'(queue_magnitude) << HEX_SHIFT;
    assign top_digit   = digits_reg[DIG_W-1 -: 4];
    assign slot_free   = !out_valid_reg || pop;

    // Double-dabble correction: every BCD digit of five or more gets three added.
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (digits_reg[4*i +: 4] >= 4'd5)
            begin
                adjusted[4*i +: 4] = digits_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adjusted[4*i +: 4] = digits_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        digits_next    = digits_reg;
        bin_next       = bin_reg;
        bit_cnt_next   = bit_cnt_reg;
        count_next     = count_reg;
        sign_next      = sign_reg;
        out_valid_next = out_valid_reg && !pop;
        char_next      = char_reg;
        last_next      = last_reg;
        queue_read     = 1'b0;

        case (state_reg)
            ita_pkg::BACK_IDLE:
            begin
                if (!queue_empty)
                begin
                    queue_read   = 1'b1;
                    sign_next    = queue_kind.negative;
                    bin_next     = queue_magnitude;
                    bit_cnt_next = BIT_W'(VALUE_BITS);
                    if (queue_kind.hex)
                    begin
                        digits_next = hex_aligned;
                        count_next  = CNT_W'(HEX_DIGITS);
                        state_next  = ita_pkg::BACK_TRIM;
                    end
                    else
                    begin
                        digits_next = '0;
                        count_next  = CNT_W'(DEC_DIGITS);
                        state_next  = ita_pkg::BACK_CONVERT;
                    end
                end
            end
            ita_pkg::BACK_CONVERT:
            begin
                digits_next  = {adjusted[DIG_W-2:0], bin_reg[VALUE_BITS-1]};
                bin_next     = bin_reg << 1;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BIT_W'(1))
                begin
                    state_next = ita_pkg::BACK_TRIM;
                end
            end
            ita_pkg::BACK_TRIM:
            begin
                // Drop leading zeros, but a lone zero digit stays.
                if ((count_reg > CNT_W'(1)) && (top_digit == 4'd0))
                begin
                    digits_next = digits_reg << 4;
                    count_next  = count_reg - 1'b1;
                end
                else
                begin
                    state_next = ita_pkg::BACK_EMIT;
                end
            end
            ita_pkg::BACK_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (sign_reg)
                    begin
                        char_next = ita_pkg::CHAR_MINUS;
                        last_next = 1'b0;
                        sign_next = 1'b0;
                    end
                    else
                    begin
                        char_next   = ita_pkg::digit_char(top_digit);
                        last_next   = (count_reg == CNT_W'(1));
                        digits_next = digits_reg << 4;
                        count_next  = count_reg - 1'b1;
                        if (count_reg == CNT_W'(1))
                        begin
                            state_next = ita_pkg::BACK_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ita_pkg::BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ita_pkg::BACK_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            count_reg     <= '0;
            sign_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            count_reg     <= count_next;
            sign_reg      <= sign_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        bin_reg    <= bin_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign character = char_reg;
    assign last      = last_reg;
    assign empty     = !out_valid_reg;

endmodule

`default_nettype wire

// File: hdl/integer_to_ascii_converter.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// request   in         push / full        value[31:0], command[1:0]
// result    out        pop / empty        character[6:0], last
//
// A decimal request leaves the queue, then goes through double-dabble shifting of all
// VALUE_BITS bits (one bit per cycle), then a trim step that drops leading zeros, then
// sends its characters, with '-' first for a negative value.
// A hex request skips the shifting and goes straight to the trim step.
// A finished character waits on pop; the next one is sent only as pop takes it.
// Reset clears the queue and the sequencer at once; no clearing pass is needed.
// A two-entry queue takes new requests while the back end works or waits on pop.

module integer_to_ascii_converter #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] value,
    input  wire logic [1:0]  command,
    input  wire logic        push,
    output logic             full,
    output logic [6:0]       character,
    output logic             last,
    output logic             empty,
    input  wire logic        pop
);

    localparam int ENTRY_W = VALUE_BITS + ita_pkg::KIND_BITS;

    logic                  queue_full;
    logic                  queue_write;
    logic [VALUE_BITS-1:0] front_magnitude;
    ita_pkg::ita_kind_t    front_kind;
    logic [ENTRY_W-1:0]    queue_out;
    logic                  queue_empty;
    logic                  queue_read;
    logic [VALUE_BITS-1:0] back_magnitude;
    ita_pkg::ita_kind_t    back_kind;

    ita_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .value          (value),
        .command        (command),
        .push           (push),
        .full           (full),
        .queue_full     (queue_full),
        .queue_write    (queue_write),
        .queue_magnitude(front_magnitude),
        .queue_kind     (front_kind)
    );

    ita_queue #(
        .WIDTH(ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .write      (queue_write),
        .write_data ({front_kind, front_magnitude}),
        .queue_full (queue_full),
        .read       (queue_read),
        .read_data  (queue_out),
        .queue_empty(queue_empty)
    );

    assign back_magnitude = queue_out[VALUE_BITS-1:0];
    assign back_kind      = ita_pkg::ita_kind_t'(queue_out[ENTRY_W-1:VALUE_BITS]);

    ita_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .queue_empty    (queue_empty),
        .queue_magnitude(back_magnitude),
        .queue_kind     (back_kind),
        .queue_read     (queue_read),
        .character      (character),
        .last           (last),
        .empty          (empty),
        .pop            (pop)
    );

endmodule

`default_nettype wire
